### src/lhs_pkg.sv
`timescale 1ns / 1ps

package lhs_pkg;

    // Operation codes carried in tuser
    localparam logic [1:0] OP_TICK       = 2'd0;
    localparam logic [1:0] OP_SET_NORMAL = 2'd1;
    localparam logic [1:0] OP_SET_TEMP   = 2'd2;
    localparam logic [1:0] OP_SET_BRIGHT = 2'd3;

    // Mode codes; 9 to 15 mean nothing and are ignored by commands
    localparam logic [3:0] MODE_OFF     = 4'd0;
    localparam logic [3:0] MODE_COLOR   = 4'd1;
    localparam logic [3:0] MODE_BLINK   = 4'd2;
    localparam logic [3:0] MODE_PULSE   = 4'd3;
    localparam logic [3:0] MODE_FADE    = 4'd4;
    localparam logic [3:0] MODE_PING    = 4'd5;
    localparam logic [3:0] MODE_FADE_TO = 4'd6;
    localparam logic [3:0] MODE_DIM     = 4'd7;
    localparam logic [3:0] MODE_DIM_TO  = 4'd8;

    localparam logic [7:0] STRIDE_UP   = 8'd1;
    localparam logic [7:0] STRIDE_DOWN = 8'd255;
    localparam logic [7:0] VAL_FULL    = 8'd255;
    localparam logic [7:0] VAL_MIN     = 8'd1;
    localparam logic [7:0] PHASE_INIT  = 8'd1;
    localparam logic [7:0] PHASE_LAST  = 8'd255;

    localparam int OP_W   = 2;
    localparam int MODE_W = 4;
    localparam int LIFE_W = 15;

    typedef enum logic [1:0] {
        EV_IDLE,
        EV_RUN,
        EV_OFF,
        EV_COLOR
    } t_event;

    typedef struct packed {
        logic [7:0] hue;
        logic [7:0] sat;
        logic [7:0] val;
    } t_hsv;

    // Context of one effect lane as seen by the step unit
    typedef struct packed {
        t_hsv       color;
        logic [7:0] stride;
        logic [7:0] phase;
    } t_lane;

    // One accepted item
    typedef struct packed {
        logic [OP_W-1:0]   op;
        logic [MODE_W-1:0] mode;
        t_hsv              color;
        logic [LIFE_W-1:0] life;
    } t_item;

    // One result item
    typedef struct packed {
        t_hsv              color;
        logic              lamp_on;
        logic              overlay_active;
        logic [MODE_W-1:0] active_mode;
    } t_result;

endpackage

### src/lhs_step.sv
`timescale 1ns / 1ps

module lhs_step
    import lhs_pkg::*;
(
    input  logic [MODE_W-1:0] i_mode,
    input  t_lane             i_lane,
    input  logic [7:0]        i_target,
    input  logic [7:0]        i_floor,
    output t_lane             o_lane,
    output t_event            o_event
);

    t_lane      lane;
    logic [7:0] phase_inc;

    assign phase_inc = i_lane.phase + 8'd1;

    // Advance one effect by one step
    always_comb begin
        lane    = i_lane;
        o_event = EV_RUN;
        case (i_mode)
            MODE_DIM_TO: begin
                if (i_lane.color.val == i_floor) begin
                    o_event = (i_floor == 8'd0) ? EV_OFF : EV_COLOR;
                end else if (i_lane.color.val > i_floor) begin
                    lane.color.val = i_lane.color.val - 8'd1;
                end else begin
                    lane.color.val = i_lane.color.val + 8'd1;
                end
            end
            MODE_DIM: begin
                if (i_lane.color.val == VAL_MIN) begin
                    o_event = EV_OFF;
                end else begin
                    lane.color.val = i_lane.color.val - 8'd1;
                end
            end
            MODE_FADE_TO: begin
                if (i_lane.color.hue == i_target) begin
                    o_event = EV_COLOR;
                end else if (i_lane.color.hue > i_target) begin
                    lane.color.hue = i_lane.color.hue - 8'd1;
                end else begin
                    lane.color.hue = i_lane.color.hue + 8'd1;
                end
            end
            MODE_FADE: begin
                lane.color.hue = i_lane.color.hue + i_lane.stride;
                // wrap to zero when climbing
                if (lane.color.hue == 8'd255 && i_lane.stride == STRIDE_UP) begin
                    lane.color.hue = 8'd0;
                end
            end
            MODE_PING: begin
                lane.color.hue = i_lane.color.hue + i_lane.stride;
                if (lane.color.hue == 8'd0) begin
                    lane.stride = STRIDE_UP;
                end else if (lane.color.hue == 8'd255) begin
                    lane.stride = STRIDE_DOWN;
                end
            end
            MODE_PULSE: begin
                lane.color.val = i_lane.color.val + i_lane.stride;
                if (lane.color.val == i_floor) begin
                    lane.stride = STRIDE_UP;
                end else if (lane.color.val == VAL_FULL) begin
                    lane.stride = STRIDE_DOWN;
                end
            end
            MODE_BLINK: begin
                lane.phase = phase_inc;
                if (phase_inc[4:0] == 5'd0) begin
                    lane.color.val = VAL_FULL;
                end else if (phase_inc[3:0] == 4'd0) begin
                    lane.color.val = VAL_MIN;
                end
                if (phase_inc == PHASE_LAST) begin
                    lane.phase = 8'd0;
                end
            end
            default: begin
                o_event = EV_IDLE;
            end
        endcase
        // keep the lamp lit while running
        if (o_event == EV_RUN && lane.color.val == 8'd0) begin
            lane.color.val = VAL_MIN;
        end
    end

    assign o_lane = lane;

endmodule

### src/lhs_engine.sv
`timescale 1ns / 1ps

module lhs_engine
    import lhs_pkg::*;
(
    input  logic    i_clk,
    input  logic    i_rst_n,
    input  logic    i_fire,
    input  t_item   i_item,
    output t_result o_result
);

    localparam t_hsv HSV_INIT = '{hue: 8'd0, sat: 8'd255, val: 8'd255};
    localparam t_hsv HSV_DARK = '{hue: 8'd0, sat: 8'd0, val: 8'd0};

    logic [MODE_W-1:0] r_nm_mode, n_nm_mode;
    logic [MODE_W-1:0] r_ov_mode, n_ov_mode;
    t_lane             r_nm_lane, n_nm_lane;
    t_lane             r_ov_lane, n_ov_lane;
    logic [7:0]        r_nm_target, n_nm_target;
    logic [7:0]        r_ov_target, n_ov_target;
    logic [7:0]        r_nm_floor, n_nm_floor;
    logic [7:0]        r_ov_floor, n_ov_floor;
    logic [LIFE_W-1:0] r_life, n_life;
    t_hsv              r_driven, n_driven;
    logic              r_enabled, n_enabled;

    logic              use_ov;
    logic [MODE_W-1:0] step_mode;
    t_lane             step_in, step_out;
    logic [7:0]        step_target, step_floor;
    t_event            step_event;
    logic              mode_known;

    // Share one step unit between the two lanes
    assign use_ov      = (r_ov_mode != MODE_OFF);
    assign step_mode   = use_ov ? r_ov_mode : r_nm_mode;
    assign step_in     = use_ov ? r_ov_lane : r_nm_lane;
    assign step_target = use_ov ? r_ov_target : r_nm_target;
    assign step_floor  = use_ov ? r_ov_floor : r_nm_floor;
    assign mode_known  = (i_item.mode <= MODE_DIM_TO);

    lhs_step u_step (
        .i_mode   (step_mode),
        .i_lane   (step_in),
        .i_target (step_target),
        .i_floor  (step_floor),
        .o_lane   (step_out),
        .o_event  (step_event)
    );

    // Next state for the accepted item
    always_comb begin
        n_nm_mode   = r_nm_mode;
        n_ov_mode   = r_ov_mode;
        n_nm_lane   = r_nm_lane;
        n_ov_lane   = r_ov_lane;
        n_nm_target = r_nm_target;
        n_ov_target = r_ov_target;
        n_nm_floor  = r_nm_floor;
        n_ov_floor  = r_ov_floor;
        n_life      = r_life;
        n_driven    = r_driven;
        n_enabled   = r_enabled;
        case (i_item.op)
            OP_TICK: begin
                if (use_ov) begin
                    n_ov_lane = step_out;
                    case (step_event)
                        EV_OFF: begin
                            n_life    = '0;
                            n_ov_mode = MODE_OFF;
                        end
                        EV_COLOR: begin
                            if (r_nm_mode == MODE_OFF) begin
                                n_enabled = 1'b1;
                            end
                            n_driven  = step_out.color;
                            n_life    = '0;
                            n_ov_mode = MODE_COLOR;
                        end
                        EV_RUN: begin
                            n_driven = step_out.color;
                            // count down the overlay lifetime
                            if (r_life == LIFE_W'(1)) begin
                                n_life    = '0;
                                n_ov_mode = MODE_OFF;
                            end else if (r_life != '0) begin
                                n_life = r_life - LIFE_W'(1);
                            end
                        end
                        default: begin
                        end
                    endcase
                end else begin
                    n_nm_lane = step_out;
                    case (step_event)
                        EV_OFF: begin
                            n_driven  = HSV_DARK;
                            n_enabled = 1'b0;
                            n_nm_mode = MODE_OFF;
                        end
                        EV_COLOR: begin
                            n_driven  = step_out.color;
                            n_nm_mode = MODE_COLOR;
                        end
                        EV_RUN: begin
                            n_driven = step_out.color;
                        end
                        default: begin
                        end
                    endcase
                end
            end
            OP_SET_BRIGHT: begin
                n_nm_lane.color.val = i_item.color.val;
            end
            OP_SET_NORMAL: begin
                if (mode_known) begin
                    case (i_item.mode)
                        MODE_FADE_TO: n_nm_target = i_item.color.hue;
                        MODE_DIM_TO:  n_nm_floor  = i_item.color.val;
                        MODE_PULSE: begin
                            n_nm_floor       = i_item.color.val;
                            n_nm_lane.stride = STRIDE_UP;
                            n_nm_lane.color  = i_item.color;
                        end
                        default: n_nm_lane.color = i_item.color;
                    endcase
                    // leaving off: start dark with outputs enabled
                    if (r_nm_mode == MODE_OFF && i_item.mode != MODE_OFF) begin
                        n_driven  = HSV_DARK;
                        n_enabled = 1'b1;
                    end
                    case (i_item.mode)
                        MODE_OFF: begin
                            n_driven  = HSV_DARK;
                            n_enabled = 1'b0;
                        end
                        MODE_COLOR: n_driven = n_nm_lane.color;
                        MODE_BLINK: n_nm_lane.phase = PHASE_INIT;
                        MODE_FADE: begin
                            n_nm_lane.stride    = STRIDE_UP;
                            n_nm_lane.color.hue = 8'd0;
                            n_nm_lane.color.sat = 8'd255;
                        end
                        MODE_PING: n_nm_lane.stride = STRIDE_UP;
                        default: begin
                        end
                    endcase
                    n_nm_mode = i_item.mode;
                end
            end
            OP_SET_TEMP: begin
                if (mode_known) begin
                    case (i_item.mode)
                        MODE_FADE_TO: n_ov_target = i_item.color.hue;
                        MODE_DIM_TO:  n_ov_floor  = i_item.color.val;
                        MODE_PULSE: begin
                            n_ov_floor       = i_item.color.val;
                            n_ov_lane.stride = STRIDE_UP;
                            n_ov_lane.color  = i_item.color;
                        end
                        default: n_ov_lane.color = i_item.color;
                    endcase
                    if (r_nm_mode == MODE_OFF && i_item.mode != MODE_OFF) begin
                        n_driven  = HSV_DARK;
                        n_enabled = 1'b1;
                    end
                    case (i_item.mode)
                        MODE_COLOR: n_driven = n_ov_lane.color;
                        MODE_BLINK: n_ov_lane.phase = PHASE_INIT;
                        MODE_FADE:  n_ov_lane.stride = STRIDE_UP;
                        MODE_PING:  n_ov_lane.stride = STRIDE_UP;
                        default: begin
                        end
                    endcase
                    n_life    = i_item.life;
                    n_ov_mode = i_item.mode;
                end
            end
            default: begin
            end
        endcase
    end

    // Report the state left behind by this item
    assign o_result.color          = n_driven;
    assign o_result.lamp_on        = n_enabled;
    assign o_result.overlay_active = (n_ov_mode != MODE_OFF);
    assign o_result.active_mode    = (n_ov_mode != MODE_OFF) ? n_ov_mode : n_nm_mode;

    // Hold the effect state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_nm_mode   <= MODE_OFF;
            r_ov_mode   <= MODE_OFF;
            r_nm_lane   <= '{color: HSV_INIT, stride: STRIDE_UP, phase: PHASE_INIT};
            r_ov_lane   <= '{color: HSV_INIT, stride: STRIDE_UP, phase: PHASE_INIT};
            r_nm_target <= 8'd0;
            r_ov_target <= 8'd0;
            r_nm_floor  <= VAL_FULL;
            r_ov_floor  <= VAL_FULL;
            r_life      <= '0;
            r_driven    <= HSV_DARK;
            r_enabled   <= 1'b0;
        end else if (i_fire) begin
            r_nm_mode   <= n_nm_mode;
            r_ov_mode   <= n_ov_mode;
            r_nm_lane   <= n_nm_lane;
            r_ov_lane   <= n_ov_lane;
            r_nm_target <= n_nm_target;
            r_ov_target <= n_ov_target;
            r_nm_floor  <= n_nm_floor;
            r_ov_floor  <= n_ov_floor;
            r_life      <= n_life;
            r_driven    <= n_driven;
            r_enabled   <= n_enabled;
        end
    end

endmodule

### src/led_hsv_effect_sequencer.sv
`timescale 1ns / 1ps
// Each item passes through the input register, then the result register; the step unit and
// command decode sit between them. Throughput: one item per cycle unless the output stalls.
// The input side stays ready while a finished result waits, as long as the result register drains.
// Reset (synchronous, active low): both modes off, colors hue 0 sat 255 val 255, floors 255,
// strides and phases 1, lifetime 0, driven color dark, outputs disabled, both stages empty.

module led_hsv_effect_sequencer
    import lhs_pkg::*;
(
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_s_axis_tvalid,
    output logic        o_s_axis_tready,
    // tdata: mode[3:0], hue_in[11:4], sat_in[19:12], val_in[27:20], life_ticks[42:28], zero
    input  logic [47:0] i_s_axis_tdata,
    // tuser: op[1:0]
    input  logic [1:0]  i_s_axis_tuser,
    output logic        o_m_axis_tvalid,
    input  logic        i_m_axis_tready,
    // tdata: hue_out[7:0], sat_out[15:8], val_out[23:16], lamp_on[24],
    //        overlay_active[25], active_mode[29:26], zero
    output logic [31:0] o_m_axis_tdata
);

    logic    r_in_valid;
    t_item   r_in;
    logic    r_out_valid;
    t_result r_out;
    logic    advance;
    logic    fire;
    logic    s_accept;
    t_result result;

    assign advance         = !r_out_valid || i_m_axis_tready;
    assign fire            = r_in_valid && advance;
    assign o_s_axis_tready = !r_in_valid || advance;
    assign s_accept        = i_s_axis_tvalid && o_s_axis_tready;

    // Capture the input transaction
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else begin
            r_in_valid <= s_accept || (r_in_valid && !fire);
        end
    end

    always_ff @(posedge i_clk) begin
        if (s_accept) begin
            r_in.op        <= i_s_axis_tuser;
            r_in.mode      <= i_s_axis_tdata[3:0];
            r_in.color.hue <= i_s_axis_tdata[11:4];
            r_in.color.sat <= i_s_axis_tdata[19:12];
            r_in.color.val <= i_s_axis_tdata[27:20];
            r_in.life      <= i_s_axis_tdata[42:28];
        end
    end

    lhs_engine u_engine (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_fire   (fire),
        .i_item   (r_in),
        .o_result (result)
    );

    // Load the result register, drop it once taken
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (fire) begin
            r_out_valid <= 1'b1;
        end else if (i_m_axis_tready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (fire) begin
            r_out <= result;
        end
    end

    assign o_m_axis_tvalid = r_out_valid;
    assign o_m_axis_tdata  = {2'b00, r_out.active_mode, r_out.overlay_active, r_out.lamp_on,
                              r_out.color.val, r_out.color.sat, r_out.color.hue};

endmodule
